// File: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, clocked on rising edge, off during reset
`define MABC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, for a property that must hold through reset as well
`define MABC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mabc_pkg.sv
// ----------------------------------------------------------------------------
// mabc_pkg
// shared types, constants and round functions of the masked aes block cipher
// ----------------------------------------------------------------------------
package mabc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0_7    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_8_15   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_16_23  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_24_31  = 3'd4;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    localparam int BASE_ROUNDS = 10;
    localparam logic [7:0] MASK_MULT = 8'h2D;
    localparam logic [7:0] RCON_INIT = 8'h01;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_INIT = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_DONE = 4'b1000
    } eng_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte i of the state sits at bits 8i+7:8i
    function automatic logic [127:0] row_shift(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [1:0]   src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? 2'(c - r) : 2'(c + r);
                t[(c*4+r)*8 +: 8] = s[(int'(src)*4+r)*8 +: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] col_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[c*32 +: 8];
            a1 = s[c*32+8 +: 8];
            a2 = s[c*32+16 +: 8];
            a3 = s[c*32+24 +: 8];
            t[c*32 +: 8]    = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            t[c*32+8 +: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            t[c*32+16 +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            t[c*32+24 +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_col_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j]   = s[c*32+j*8 +: 8];
                x2     = xt(a[j]);
                x4     = xt(x2);
                x8     = xt(x4);
                m9[j]  = x8 ^ a[j];
                m11[j] = x8 ^ x2 ^ a[j];
                m13[j] = x8 ^ x4 ^ a[j];
                m14[j] = x8 ^ x4 ^ x2;
            end
            t[c*32 +: 8]    = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            t[c*32+8 +: 8]  = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            t[c*32+16 +: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            t[c*32+24 +: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
        return t;
    endfunction

endpackage

// File: rtl/mabc_if.sv
// ----------------------------------------------------------------------------
// mabc_req_if / mabc_res_if
// valid/ready channels for plaintext requests and cipher results
// ----------------------------------------------------------------------------
interface mabc_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] block_low;
    logic [63:0] block_high;

    modport source (output valid, output mode, output block_low, output block_high,
                    input ready);
    modport sink   (input valid, input mode, input block_low, input block_high,
                    output ready);
endinterface

interface mabc_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;

    modport source (output valid, output result_low, output result_high, input ready);
    modport sink   (input valid, input result_low, input result_high, output ready);
endinterface

// File: rtl/mabc_key_expand.sv
// ----------------------------------------------------------------------------
// mabc_key_expand
// sequential key schedule, one 32-bit word per cycle, and mask byte derivation
// ----------------------------------------------------------------------------
module mabc_key_expand #(
    parameter int MAX_ROUNDS = 14,
    parameter int RW = $clog2(MAX_ROUNDS + 1),
    parameter int AW = RW + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         ks,
    input  logic [RW-1:0]      nr,
    input  logic [3:0][63:0]   key,
    output logic               busy,
    output logic [7:0]         mask,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [63:0]        wr_data
);
    import mabc_pkg::*;

    localparam int KW = RW + 2;

    logic          busy_reg, busy_next;
    logic [KW-1:0] k_reg, k_next;
    logic [2:0]    phase_reg, phase_next;
    logic [7:0]    rc_reg, rc_next;
    logic [7:0]    mask_reg, mask_next;
    logic [31:0]   win_reg [8];
    logic [31:0]   word;
    logic [31:0]   t;
    logic [31:0]   back;
    logic [3:0]    nk;
    logic          from_key;
    logic [63:0]   seed_reg;
    logic [7:0]    seed_lo;
    logic [15:0]   prod;

    assign nk       = (ks == KS_128) ? 4'd4 : (ks == KS_192) ? 4'd6 : 4'd8;
    assign from_key = ({{(KW-4){1'b0}}, nk} > k_reg);
    assign back     = (ks == KS_128) ? win_reg[4] : (ks == KS_192) ? win_reg[2] : win_reg[0];

    // seed is the last key register byte reversed; only its low 11 bits matter
    assign seed_reg = key[2'(ks + 2'd1)];
    assign seed_lo  = seed_reg[63:56] ^ {seed_reg[50:48], seed_reg[63:59]};
    assign prod     = seed_lo * MASK_MULT;

    always_comb
    begin
        t = win_reg[7];
        if (phase_reg == 3'd0)
        begin
            t = sub_word({win_reg[7][7:0], win_reg[7][31:8]}) ^ {24'd0, rc_reg};
        end
        else if (ks == KS_256 && phase_reg == 3'd4)
        begin
            t = sub_word(win_reg[7]);
        end
        word = from_key ? key[k_reg[2:1]][k_reg[0]*32 +: 32] : (back ^ t);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        k_next     = k_reg;
        phase_next = phase_reg;
        rc_next    = rc_reg;
        mask_next  = mask_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            k_next     = '0;
            phase_next = '0;
            rc_next    = RCON_INIT;
            mask_next  = prod[7:0];
        end
        else if (busy_reg)
        begin
            k_next     = k_reg + KW'(1);
            phase_next = ({1'b0, phase_reg} == nk - 4'd1) ? 3'd0 : phase_reg + 3'd1;
            if (!from_key && phase_reg == 3'd0)
            begin
                rc_next = xt(rc_reg);
            end
            if (k_reg == {nr, 2'b11})
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            k_reg     <= '0;
            phase_reg <= '0;
            rc_reg    <= RCON_INIT;
            mask_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
            rc_reg    <= rc_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            for (int i = 0; i < 7; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[7] <= word;
        end
    end

    assign busy    = busy_reg;
    assign mask    = mask_reg;
    assign wr_en   = busy_reg && !start && k_reg[0];
    assign wr_addr = k_reg[KW-1:1];
    assign wr_data = {word, win_reg[7]};

endmodule

// File: rtl/mabc_round_engine.sv
// ----------------------------------------------------------------------------
// mabc_round_engine
// round key memory and iterative round datapath, one round per cycle
// ----------------------------------------------------------------------------
module mabc_round_engine #(
    parameter int MAX_ROUNDS = 14,
    parameter int RW = $clog2(MAX_ROUNDS + 1),
    parameter int AW = RW + 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hold,
    input  logic [RW-1:0] nr,
    input  logic [7:0]    mask,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data,
    mabc_req_if.sink      req,
    mabc_res_if.source    res
);
    import mabc_pkg::*;

    localparam int DEPTH = 2 * (MAX_ROUNDS + 1);

    logic [63:0]   rk_mem [DEPTH];
    logic [63:0]   rk_lo_q, rk_hi_q;
    logic [127:0]  rk;

    eng_state_t    state_reg, state_next;
    logic [127:0]  h_reg, h_next;
    logic          dec_reg, dec_next;
    logic [RW-1:0] kround_reg, kround_next;
    logic [RW-1:0] step_reg, step_next;
    logic          out_valid_reg, out_valid_next;
    logic [127:0]  out_reg, out_next;
    logic          last;
    logic [127:0]  round_out;
    logic [127:0]  enc_t, dec_t, dec_s;
    logic [63:0]   r64;

    // round key read, data arrives the cycle after the address
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rk_mem[wr_addr] <= wr_data;
        end
        rk_lo_q <= rk_mem[{kround_next, 1'b0}];
        rk_hi_q <= rk_mem[{kround_next, 1'b1}];
    end

    assign rk   = {rk_hi_q, rk_lo_q};
    assign r64  = {56'd0, mask};
    assign last = (step_reg == nr);

    always_comb
    begin
        enc_t = row_shift({(h_reg[127:64] ^ r64) + r64, (h_reg[63:0] ^ r64) + r64}, 1'b0);
        if (!last)
        begin
            enc_t = col_mix(enc_t);
        end
        dec_s = row_shift(h_reg, 1'b1);
        dec_t = {(dec_s[127:64] - r64) ^ r64, (dec_s[63:0] - r64) ^ r64} ^ rk;
        if (!last)
        begin
            dec_t = inv_col_mix(dec_t);
        end
        round_out = dec_reg ? dec_t : (enc_t ^ rk);
    end

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        dec_next       = dec_reg;
        kround_next    = kround_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_next       = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    h_next      = {req.block_high, req.block_low};
                    dec_next    = req.mode;
                    kround_next = req.mode ? nr : '0;
                    state_next  = ST_INIT;
                end
            end
            ST_INIT:
            begin
                h_next      = h_reg ^ rk;
                step_next   = RW'(1);
                kround_next = dec_reg ? kround_reg - RW'(1) : kround_reg + RW'(1);
                state_next  = ST_RUN;
            end
            ST_RUN:
            begin
                h_next = round_out;
                if (last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next   = step_reg + RW'(1);
                    kround_next = dec_reg ? kround_reg - RW'(1) : kround_reg + RW'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = h_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            kround_reg    <= '0;
            step_reg      <= '0;
            dec_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            kround_reg    <= kround_next;
            step_reg      <= step_next;
            dec_reg       <= dec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        out_reg <= out_next;
    end

    assign req.ready       = (state_reg == ST_IDLE) && !hold;
    assign res.valid       = out_valid_reg;
    assign res.result_low  = out_reg[63:0];
    assign res.result_high = out_reg[127:64];

endmodule

// File: rtl/masked_aes_block_cipher_top.sv
// ----------------------------------------------------------------------------
// masked_aes_block_cipher_top
// masked aes-128/192/256 ecb block cipher with a configuration write port
// ----------------------------------------------------------------------------
// usage
//  - req carries one 128-bit block and a mode bit (0 encrypt, 1 decrypt);
//    res returns one 128-bit block per request, in order
//  - both channels are valid/ready; a request is taken when both are high
//  - configuration: cfg_we with cfg_index 0 (key size) to 4 (key bytes 24-31);
//    every write to an existing register expands the round keys again, and
//    req.ready stays low meanwhile
//  - a block first gets the first round key added, then runs nr rounds
//    (nr = 10, 12, 14) at one round per cycle on a shared round unit fed by
//    the round key memory; the next request is taken only after the result
//    is loaded into the output register
//  - a result waiting on a stalled receiver sits in the output register; the
//    engine takes the next request meanwhile and holds its own result until
//    the output register frees up
//  - reset clears configuration to zero and empties the output register; the
//    round key memory holds nothing valid until a configuration write
// ----------------------------------------------------------------------------
module masked_aes_block_cipher_top #(
    parameter int MAX_ROUNDS = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mabc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    mabc_req_if.sink                      req,
    mabc_res_if.source                    res
);
    import mabc_pkg::*;

    localparam int RW = $clog2(MAX_ROUNDS + 1);
    localparam int AW = RW + 1;

    // configuration registers
    logic [1:0]       key_size_reg;
    logic [3:0][63:0] key_reg;
    logic             start_reg;

    logic [1:0]       ks_sat;
    logic [RW-1:0]    nr_full;
    logic [RW-1:0]    nr;

    logic             exp_busy;
    logic [7:0]       mask;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [63:0]      wr_data;
    logic             hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= '0;
            key_reg      <= '0;
            start_reg    <= 1'b0;
        end
        else
        begin
            // expansion starts the cycle after the write, on the new values
            start_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_SIZE:
                    begin
                        key_size_reg <= cfg_data[1:0];
                        start_reg    <= 1'b1;
                    end
                    CFG_KEY_0_7:
                    begin
                        key_reg[0] <= cfg_data;
                        start_reg  <= 1'b1;
                    end
                    CFG_KEY_8_15:
                    begin
                        key_reg[1] <= cfg_data;
                        start_reg  <= 1'b1;
                    end
                    CFG_KEY_16_23:
                    begin
                        key_reg[2] <= cfg_data;
                        start_reg  <= 1'b1;
                    end
                    CFG_KEY_24_31:
                    begin
                        key_reg[3] <= cfg_data;
                        start_reg  <= 1'b1;
                    end
                    default:
                    begin
                        // unknown index, ignored
                    end
                endcase
            end
        end
    end

    // key size three acts as 256-bit; round count capped at MAX_ROUNDS
    assign ks_sat  = (key_size_reg > KS_256) ? KS_256 : key_size_reg;
    assign nr_full = RW'(BASE_ROUNDS) + RW'({ks_sat, 1'b0});
    assign nr      = (nr_full > RW'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : nr_full;

    // no requests while the round keys are rebuilt
    assign hold = cfg_we || start_reg || exp_busy;

    mabc_key_expand #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .RW         (RW),
        .AW         (AW)
    ) u_key_expand (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .ks      (ks_sat),
        .nr      (nr),
        .key     (key_reg),
        .busy    (exp_busy),
        .mask    (mask),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    mabc_round_engine #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .RW         (RW),
        .AW         (AW)
    ) u_round_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .hold    (hold),
        .nr      (nr),
        .mask    (mask),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .req     (req),
        .res     (res)
    );

endmodule

// File: rtl/mabc_checker.sv
// ----------------------------------------------------------------------------
// mabc_checker
// port-level checks of the cipher top, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mabc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_we,
    input logic [mabc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [63:0]                    res_low,
    input logic [63:0]                    res_high
);
    import mabc_pkg::*;

    logic req_take;
    logic cfg_hit;

    assign req_take = req_valid && req_ready;
    assign cfg_hit  = cfg_we && (cfg_index <= CFG_KEY_24_31);

    `MABC_ASSERT(a_res_hold, clk, rst_n, res_valid && !res_ready |=> res_valid && $stable(res_low) && $stable(res_high), "stalled result changed")
    `MABC_ASSERT(a_cfg_blocks, clk, rst_n, cfg_hit |=> !req_ready, "request taken during key expansion")
    `MABC_ASSERT(a_one_at_a_time, clk, rst_n, req_take |=> !req_ready, "second request taken while busy")
    `MABC_ASSERT(a_no_early_result, clk, rst_n, req_take |=> !$rose(res_valid), "result too early after request")

endmodule

bind masked_aes_block_cipher_top mabc_checker u_mabc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_low   (res.result_low),
    .res_high  (res.result_high)
);

// File: test/tb_masked_aes_block_cipher_top.sv
// ----------------------------------------------------------------------------
// tb_masked_aes_block_cipher_top
// self-checking bench: drives encrypt and decrypt requests under several key
// setups and compares every result against a cycle-free cipher predictor
// ----------------------------------------------------------------------------
module tb_masked_aes_block_cipher_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mabc_pkg::*;

    localparam int  LIMIT_CYCLES = 600000;
    localparam int  RK_ENTRIES   = 30;
    localparam bit  MODE_ENC     = 1'b0;
    localparam bit  MODE_DEC     = 1'b1;
    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SEED_MULT = 64'd6364136223846793005;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } block_t;

    typedef struct {
        bit          mode;
        logic [63:0] lo;
        logic [63:0] hi;
    } block_req_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0] cfg_data;

    mabc_req_if req_ch();
    mabc_res_if res_ch();

    masked_aes_block_cipher_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    // predictor copy of the configuration and key state
    logic [1:0]  key_size_q;
    logic [63:0] key_regs [4];
    logic [63:0] round_keys [RK_ENTRIES];
    logic [7:0]  mask_q;

    block_t pending_blocks [$];
    int     fail_count;
    int     cycle_count;
    bit     no_idle;        // long stretch with no gaps on either side

    // directed blocks: extremes, alternating bits, single bits, both modes.
    // nothing here can be read off by hand once the masked rounds run, so
    // every row goes through the predictor
    block_req_t directed_rows [12] = '{
        '{MODE_ENC, 64'h0, 64'h0},
        '{MODE_DEC, 64'h0, 64'h0},
        '{MODE_ENC, ONES, ONES},
        '{MODE_DEC, ONES, ONES},
        '{MODE_ENC, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
        '{MODE_DEC, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
        '{MODE_ENC, 64'h1, 64'h0},
        '{MODE_DEC, 64'h0, 64'h8000_0000_0000_0000},
        '{MODE_ENC, 64'h8000_0000_0000_0000, 64'h1},
        '{MODE_DEC, ONES, 64'h0},
        '{MODE_ENC, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF},
        '{MODE_DEC, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF}
    };

    // clock, 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // cipher predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = gf_double(a);
        end
        return p;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        logic [31:0] o;
        for (int i = 0; i < 4; i++)
            o[i*8 +: 8] = SBOX[w[i*8 +: 8]];
        return o;
    endfunction

    // rebuild round keys and the mask byte from the register copies
    function automatic void rebuild_key_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        logic [63:0] s;
        int ks, nk, nr, total;
        ks    = (key_size_q > 2) ? 2 : int'(key_size_q);
        nk    = 4 + 2 * ks;
        nr    = 10 + 2 * ks;
        total = 4 * (nr + 1);
        rc    = 8'h01;
        for (int k = 0; k < nk; k++)
            w[k] = key_regs[k >> 1][(k & 1) * 32 +: 32];
        for (int k = nk; k < total; k++)
        begin
            t = w[k-1];
            if (k % nk == 0)
            begin
                t  = sbox_word({t[7:0], t[31:8]}) ^ {24'h0, rc};
                rc = gf_double(rc);
            end
            else if (nk > 6 && k % nk == 4)
                t = sbox_word(t);
            w[k] = w[k-nk] ^ t;
        end
        for (int k = 0; k < total / 2; k++)
            round_keys[k] = {w[2*k+1], w[2*k]};
        // seed is the last eight key bytes read big-endian
        s = {<<8{key_regs[nk/2 - 1]}};
        s = s ^ (s >> 3);
        s = s * SEED_MULT;
        mask_q = s[7:0];
    endfunction

    function automatic logic [127:0] rotate_rows(input logic [127:0] st, input bit inv);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? ((c - r) & 3) : ((c + r) & 3);
                t[(c*4+r)*8 +: 8] = st[(src*4+r)*8 +: 8];
            end
        return t;
    endfunction

    function automatic logic [127:0] mix_state(input logic [127:0] st, input bit inv);
        logic [127:0] t;
        logic [7:0] coef [4];
        logic [7:0] acc;
        if (inv)
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_mul(coef[(k - j) & 3], st[(c*4+k)*8 +: 8]);
                t[(c*4+j)*8 +: 8] = acc;
            end
        return t;
    endfunction

    // whole-half masked substitution on both 64-bit halves
    function automatic logic [127:0] mask_halves(input logic [127:0] st, input bit inv);
        logic [63:0] r;
        logic [63:0] h [2];
        r = {56'h0, mask_q};
        h[0] = st[63:0];
        h[1] = st[127:64];
        for (int i = 0; i < 2; i++)
            h[i] = inv ? ((h[i] - r) ^ r) : ((h[i] ^ r) + r);
        return {h[1], h[0]};
    endfunction

    function automatic logic [127:0] round_key(input int i);
        return {round_keys[2*i+1], round_keys[2*i]};
    endfunction

    function automatic block_t cipher_block(input bit mode, input logic [63:0] lo,
                                            input logic [63:0] hi);
        logic [127:0] st;
        int nr;
        nr = 10 + 2 * ((key_size_q > 2) ? 2 : int'(key_size_q));
        st = {hi, lo};
        if (mode == MODE_ENC)
        begin
            st ^= round_key(0);
            for (int i = 1; i < nr; i++)
                st = mix_state(rotate_rows(mask_halves(st, 0), 0), 0) ^ round_key(i);
            st = rotate_rows(mask_halves(st, 0), 0) ^ round_key(nr);
        end
        else
        begin
            st ^= round_key(nr);
            for (int i = nr - 1; i > 0; i--)
                st = mix_state(mask_halves(rotate_rows(st, 1), 1) ^ round_key(i), 1);
            st = mask_halves(rotate_rows(st, 1), 1) ^ round_key(0);
        end
        return '{lo: st[63:0], hi: st[127:64]};
    endfunction

    // ------------------------------------------------------------------
    // monitors, sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            pending_blocks.push_back(cipher_block(req_ch.mode, req_ch.block_low,
                                                  req_ch.block_high));
    end

    always @(posedge clk)
    begin
        block_t exp_blk;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_blocks.size() == 0)
            begin
                $error("result with no request outstanding: low %h high %h",
                       res_ch.result_low, res_ch.result_high);
                fail_count++;
            end
            else
            begin
                exp_blk = pending_blocks.pop_front();
                if (res_ch.result_low !== exp_blk.lo)
                begin
                    $error("result_low: expected %h, actual %h", exp_blk.lo,
                           res_ch.result_low);
                    fail_count++;
                end
                if (res_ch.result_high !== exp_blk.hi)
                begin
                    $error("result_high: expected %h, actual %h", exp_blk.hi,
                           res_ch.result_high);
                    fail_count++;
                end
            end
        end
    end

    // receiver backpressure, ready dropped about one time in ten unless no_idle is set
    always @(negedge clk)
        res_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 10);

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("masked_aes_block_cipher_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------

    // hold the sender until every outstanding result has come back
    task automatic wait_results_drained();
        while (pending_blocks.size() != 0)
            @(posedge clk);
    endtask

    // register write while idle, then wait for key expansion to finish
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        wait_results_drained();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_KEY_SIZE)
            key_size_q = data[1:0];
        else if (idx <= CFG_KEY_24_31)
            key_regs[idx - 1] = data;
        if (idx <= CFG_KEY_24_31)
            rebuild_key_schedule();
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        write_reg(CFG_KEY_0_7, k0);
        write_reg(CFG_KEY_8_15, k1);
        write_reg(CFG_KEY_16_23, k2);
        write_reg(CFG_KEY_24_31, k3);
        write_reg(CFG_KEY_SIZE, {62'h0, ks});
    endtask

    // one request; called at a falling edge, returns at a falling edge
    task automatic send_block(input bit mode, input logic [63:0] lo, input logic [63:0] hi);
        while (!no_idle && $urandom_range(99) < 10)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.mode       = mode;
        req_ch.block_low  = lo;
        req_ch.block_high = hi;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic end_burst();
        req_ch.valid = 1'b0;
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mostly random blocks, some corner patterns
    function automatic logic [63:0] rand_half();
        case ($urandom_range(9))
            0:       return 64'h0;
            1:       return ONES;
            2:       return 64'h1 << $urandom_range(63);
            3:       return ~(64'h1 << $urandom_range(63));
            default: return rand_word();
        endcase
    endfunction

    task automatic random_burst(input int count);
        for (int i = 0; i < count; i++)
            send_block(bit'($urandom_range(1)), rand_half(), rand_half());
        end_burst();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_KEY_SIZE;
        cfg_data          = 64'h0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_ENC;
        req_ch.block_low  = 64'h0;
        req_ch.block_high = 64'h0;
        res_ch.ready      = 1'b0;
        no_idle           = 1'b0;
        fail_count        = 0;
        cycle_count       = 0;
        key_size_q        = KS_128;
        foreach (key_regs[i])
            key_regs[i] = 64'h0;
        foreach (round_keys[i])
            round_keys[i] = 64'h0;
        mask_q = 8'h00;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all-zero 128-bit key: zero mask, substitution degenerates
        load_key(KS_128, 64'h0, 64'h0, 64'h0, 64'h0);
        @(negedge clk);
        foreach (directed_rows[i])
            send_block(directed_rows[i].mode, directed_rows[i].lo, directed_rows[i].hi);
        end_burst();

        // all-ones key with key size three (acts as 256-bit), then writes
        // to indices past the last register, which must change nothing
        load_key(2'd3, ONES, ONES, ONES, ONES);
        write_reg(3'd5, rand_word());
        write_reg(3'd7, 64'h0);
        @(negedge clk);
        foreach (directed_rows[i])
            send_block(directed_rows[i].mode, directed_rows[i].lo, directed_rows[i].hi);
        end_burst();

        // random phases: each key size, random keys, one no-idle stretch
        for (int ph = 0; ph < 9; ph++)
        begin
            load_key(ph < 3 ? 2'(ph) : 2'($urandom_range(3)),
                     rand_word(), rand_word(), rand_word(), rand_word());
            no_idle = (ph == 4);
            @(negedge clk);
            random_burst(60);
            // sender holds off until everything is back, then resumes
            wait_results_drained();
            @(negedge clk);
            random_burst(70);
            no_idle = 1'b0;
        end

        // 192-bit key where only an unused register changes between bursts
        load_key(KS_192, rand_word(), rand_word(), rand_word(), ONES);
        @(negedge clk);
        random_burst(80);
        write_reg(CFG_KEY_24_31, rand_word());
        @(negedge clk);
        random_burst(70);

        wait_results_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("masked_aes_block_cipher_top: match");
        else
            $display("masked_aes_block_cipher_top: mismatch");
        $finish;
    end

endmodule
